@@ rtl/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg: shared definitions of the ray/box slab test core
// Fixed-point widths, register indexes, pipeline record types and the
// saturation of a slab distance to the distance range.
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int DIST_W    = 48;
	localparam int TOL_W     = 16;
	// Magnitude of (bound - origin) shifted left by the fraction bits.
	localparam int NUM_W     = COORD_W + FRAC_BITS;
	// Signed scratch width for the saturation compare.
	localparam int EXT_W     = NUM_W + DIST_W;
	localparam int LANES     = 6;
	localparam int AXES      = 3;
	localparam int ADDR_W    = 5;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X    = 3'd3;
	localparam logic [2:0] REG_DIR_Y    = 3'd4;
	localparam logic [2:0] REG_DIR_Z    = 3'd5;
	localparam logic [2:0] REG_TOL      = 3'd6;

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// One division in flight: dividend magnitude, partial remainder,
	// partial quotient and the sign of the result.
	typedef struct packed {
		logic [NUM_W-1:0]   num;
		logic [COORD_W-1:0] rem;
		logic [NUM_W-1:0]   quo;
		logic               neg;
	} lane_t;

	// Per-item flags that ride along with the divisions.
	typedef struct packed {
		logic            kill;
		logic            pmiss;
		logic [AXES-1:0] par;
	} side_t;

	function automatic logic signed [DIST_W-1:0] sat_dist(
		input logic [NUM_W-1:0] q,
		input logic             neg
	);
		logic signed [EXT_W-1:0] v;
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		v  = {{DIST_W{1'b0}}, q};
		if (neg) begin
			v = -v;
		end
		hi = {{NUM_W{1'b0}}, DIST_MAX};
		lo = {{NUM_W{1'b1}}, DIST_MIN};
		if (v > hi) begin
			return DIST_MAX;
		end else if (v < lo) begin
			return DIST_MIN;
		end
		return v[DIST_W-1:0];
	endfunction

endpackage

@@ rtl/ray_box_slab_test_core.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray versus axis-aligned box slab test
// Streams boxes against a ray held in registers and returns hit, entry and
// exit distance for every box.
// ----------------------------------------------------------------------------
// The core takes one box per clock while the output is not stalled, and
// returns one result per box, in order. Six pipelined restoring dividers, one
// per slab plane, produce one quotient bit per stage over 48 stages; one stage
// in front prepares the operands and four behind saturate, order and combine
// the distances and decide the hit. A stall on the output freezes the whole
// pipeline. Ray registers may only be written while no box is in flight.
module ray_box_slab_test_core
	import rbst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [191:0]        s_axis_tdata,
	// is_leaf, leaf_trimmed
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// hit, entry_distance, exit_distance, zero fill
	output logic [103:0]        m_axis_tdata,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [COORD_W-1:0] origin_q [AXES];
	logic [COORD_W-1:0] dir_q [AXES];
	logic [TOL_W-1:0]   tol_q;

	logic               en;
	logic [COORD_W-1:0] dmag [AXES];
	logic [AXES-1:0]    par;

	// Entry k of the divider arrays is the register after k quotient bits.
	lane_t              lane_s1 [NUM_W+1][LANES];
	side_t              side_s1 [NUM_W+1];
	logic               vld_s1 [NUM_W+1];
	lane_t              lane_in [LANES];
	side_t              side_in;
	lane_t              lane_nx [NUM_W][LANES];

	logic signed [DIST_W-1:0] t_s3 [LANES];
	side_t                    side_s3;
	logic                     vld_s3;
	logic signed [DIST_W-1:0] lo_s4 [AXES];
	logic signed [DIST_W-1:0] hi_s4 [AXES];
	logic                     kill_s4, pmiss_s4, vld_s4;
	logic signed [DIST_W-1:0] near_s5, far_s5;
	logic                     kill_s5, pmiss_s5, vld_s5;
	logic signed [DIST_W-1:0] near_s6, far_s6;
	logic                     hit_s6, vld_s6;

	function automatic logic signed [DIST_W-1:0] max3(
		input logic signed [DIST_W-1:0] a,
		input logic signed [DIST_W-1:0] b,
		input logic signed [DIST_W-1:0] c
	);
		logic signed [DIST_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic signed [DIST_W-1:0] min3(
		input logic signed [DIST_W-1:0] a,
		input logic signed [DIST_W-1:0] b,
		input logic signed [DIST_W-1:0] c
	);
		logic signed [DIST_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			dir_q[0]    <= 32'd65536;
			dir_q[1]    <= '0;
			dir_q[2]    <= '0;
			tol_q       <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_ORIGIN_X: origin_q[0] <= pwdata;
				REG_ORIGIN_Y: origin_q[1] <= pwdata;
				REG_ORIGIN_Z: origin_q[2] <= pwdata;
				REG_DIR_X:    dir_q[0]    <= pwdata;
				REG_DIR_Y:    dir_q[1]    <= pwdata;
				REG_DIR_Z:    dir_q[2]    <= pwdata;
				REG_TOL:      tol_q       <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ORIGIN_X: prdata = origin_q[0];
			REG_ORIGIN_Y: prdata = origin_q[1];
			REG_ORIGIN_Z: prdata = origin_q[2];
			REG_DIR_X:    prdata = dir_q[0];
			REG_DIR_Y:    prdata = dir_q[1];
			REG_DIR_Z:    prdata = dir_q[2];
			REG_TOL:      prdata = {{(32-TOL_W){1'b0}}, tol_q};
			default:      prdata = '0;
		endcase
	end

	// The whole pipeline advances unless the output holds a result not taken.
	assign en            = !vld_s6 || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: operand preparation. The user must keep the ray stable while items are in flight; not enforced.
	always_comb begin
		logic signed [COORD_W:0] diff;
		logic [COORD_W:0]        dm;
		logic signed [COORD_W-1:0] bnd;
		logic signed [COORD_W-1:0] org;
		side_in.kill  = s_axis_tuser[0] && s_axis_tuser[1];
		side_in.pmiss = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			dmag[a] = dir_q[a][COORD_W-1] ? COORD_W'(-dir_q[a]) : dir_q[a];
			par[a]  = dmag[a] <= {{(COORD_W-TOL_W){1'b0}}, tol_q};
			org     = $signed(origin_q[a]);
			if (par[a] && (org < $signed(s_axis_tdata[a*COORD_W +: COORD_W]) ||
			               org > $signed(s_axis_tdata[(a+3)*COORD_W +: COORD_W]))) begin
				side_in.pmiss = 1'b1;
			end
			for (int b = 0; b < 2; b++) begin
				bnd  = $signed(s_axis_tdata[(a+3*b)*COORD_W +: COORD_W]);
				diff = {bnd[COORD_W-1], bnd} - {org[COORD_W-1], org};
				dm   = diff[COORD_W] ? -diff : diff;
				lane_in[a*2+b].num = {dm[COORD_W-1:0], {FRAC_BITS{1'b0}}};
				lane_in[a*2+b].rem = '0;
				lane_in[a*2+b].quo = '0;
				lane_in[a*2+b].neg = diff[COORD_W] ^ dir_q[a][COORD_W-1];
			end
		end
		side_in.par = par;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (en) begin
			vld_s1[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1[0] <= lane_in;
			side_s1[0] <= side_in;
		end
	end

	// Divider stages: one restoring step per stage, quotient MSB first.
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		always_comb begin
			logic [COORD_W:0] sh;
			logic             ge;
			for (int l = 0; l < LANES; l++) begin
				sh = {lane_s1[k][l].rem, lane_s1[k][l].num[NUM_W-1-k]};
				ge = sh >= {1'b0, dmag[l/2]};
				lane_nx[k][l] = lane_s1[k][l];
				lane_nx[k][l].rem = ge ? COORD_W'(sh - {1'b0, dmag[l/2]})
				                       : sh[COORD_W-1:0];
				lane_nx[k][l].quo[NUM_W-1-k] = ge;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k+1] <= 1'b0;
			end else if (en) begin
				vld_s1[k+1] <= vld_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s1[k+1] <= lane_nx[k];
				side_s1[k+1] <= side_s1[k];
			end
		end
	end

	// Saturate, order per axis, combine across axes, then decide the hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s1[NUM_W];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				t_s3[l] <= sat_dist(lane_s1[NUM_W][l].quo, lane_s1[NUM_W][l].neg);
			end
			side_s3 <= side_s1[NUM_W];

			// A parallel axis leaves the interval open on both ends.
			for (int a = 0; a < AXES; a++) begin
				if (side_s3.par[a]) begin
					lo_s4[a] <= DIST_MIN;
					hi_s4[a] <= DIST_MAX;
				end else if (t_s3[2*a] > t_s3[2*a+1]) begin
					lo_s4[a] <= t_s3[2*a+1];
					hi_s4[a] <= t_s3[2*a];
				end else begin
					lo_s4[a] <= t_s3[2*a];
					hi_s4[a] <= t_s3[2*a+1];
				end
			end
			kill_s4  <= side_s3.kill;
			pmiss_s4 <= side_s3.pmiss;

			near_s5  <= max3(lo_s4[0], lo_s4[1], lo_s4[2]);
			far_s5   <= min3(hi_s4[0], hi_s4[1], hi_s4[2]);
			kill_s5  <= kill_s4;
			pmiss_s5 <= pmiss_s4;

			near_s6  <= near_s5;
			far_s6   <= far_s5;
			hit_s6   <= !pmiss_s5 && !kill_s5 && !(near_s5 > far_s5);
		end
	end

	assign m_axis_tvalid = vld_s6;
	assign m_axis_tdata  = {7'b0, far_s6, near_s6, hit_s6};

endmodule
